>>> rtl/core/line_segment_dedup_filter_defines.svh
// Assertion macros for the line segment dedup filter.
// Used by line_segment_dedup_filter.sv; expects i_clk and i_rst_n in scope.
`ifndef LINE_SEGMENT_DEDUP_FILTER_DEFINES_SVH
`define LINE_SEGMENT_DEDUP_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSDF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lsdf_pkg.sv
// Package for the line segment dedup filter: sequencer states and defaults.
// No dependencies.
`timescale 1ns / 1ps

package lsdf_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_COORD_BITS   = 16;

    localparam int              THR_W     = 10;
    localparam logic [THR_W-1:0] THR_RESET = 10'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/line_segment_dedup_filter.sv
// Near-duplicate line segment filter: top level with segment store and scan sequencer.
// Depends on lsdf_pkg and line_segment_dedup_filter_defines.svh.
`timescale 1ns / 1ps
`include "line_segment_dedup_filter_defines.svh"

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------------
// segment   | in        | start & !busy              | i_start_x/y, i_end_x/y, i_last_in_frame
// result    | out       | o_result_valid (1 cycle)   | o_kept, o_out_*, o_frame_end,
//           |           |                            | o_store_overflow
// config    | in        | i_cfg_valid & o_cfg_ready  | i_cfg_data (match threshold)
//
// After acceptance the sequencer scans the N segments stored in the current frame (up to
// MAX_SEGMENTS) in ST_SCAN, then fires the result and may write the store in ST_DONE: the store's
// single read port delivers one stored segment per cycle to the shared compare unit.
// busy is high from acceptance until the result strobe. Reset empties the store
// at once (fill count) and sets the threshold to 10. Results cannot be stalled.
module line_segment_dedup_filter #(
    parameter int MAX_SEGMENTS = lsdf_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = lsdf_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // segment in
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_last_in_frame,
    // result out
    output logic                         o_result_valid,
    output logic                         o_kept,
    output logic signed [COORD_BITS-1:0] o_out_start_x,
    output logic signed [COORD_BITS-1:0] o_out_start_y,
    output logic signed [COORD_BITS-1:0] o_out_end_x,
    output logic signed [COORD_BITS-1:0] o_out_end_y,
    output logic                         o_frame_end,
    output logic                         o_store_overflow,
    // config
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lsdf_pkg::THR_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_W = 4 * COORD_BITS;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int CMP_W = (DIF_W > lsdf_pkg::THR_W) ? DIF_W : lsdf_pkg::THR_W;

    lsdf_pkg::t_state r_state, n_state;

    logic [lsdf_pkg::THR_W-1:0] r_thresh;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_addr, n_addr;
    logic                       r_rd_pend;
    logic                       r_dup, n_dup;
    logic [SEG_W-1:0]           r_seg;
    logic                       r_last;
    logic [SEG_W-1:0]           r_rd_data;

    logic [SEG_W-1:0] mem [MAX_SEGMENTS];

    logic rd_en, wr_en, res_fire, store_full, scan_end, match;

    logic                       r_result_valid;
    logic                       r_kept;
    logic                       r_frame_end;
    logic                       r_overflow;
    logic [SEG_W-1:0]           r_out_seg;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= lsdf_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    // ---------------- shared compare unit ----------------
    // Four endpoint differences at COORD_BITS+1 bits, against the registered read data.
    always_comb begin
        logic signed [DIF_W-1:0] a, b, d;
        logic [CMP_W-1:0]        mag;
        match = 1'b1;
        for (int k = 0; k < 4; k++) begin
            a   = DIF_W'($signed(r_seg[k*COORD_BITS +: COORD_BITS]));
            b   = DIF_W'($signed(r_rd_data[k*COORD_BITS +: COORD_BITS]));
            d   = a - b;
            mag = d[DIF_W-1] ? CMP_W'(-d) : CMP_W'(d);
            if (!(mag < CMP_W'(r_thresh))) begin
                match = 1'b0;
            end
        end
    end

    assign store_full = (r_count == CNT_W'(MAX_SEGMENTS));
    assign scan_end   = (r_addr == r_count) && !r_rd_pend;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsdf_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lsdf_pkg::ST_SCAN;
                end
            end
            lsdf_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = lsdf_pkg::ST_DONE;
                end
            end
            lsdf_pkg::ST_DONE: begin
                n_state = lsdf_pkg::ST_IDLE;
            end
            default: begin
                n_state = lsdf_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        res_fire = 1'b0;
        n_addr   = r_addr;
        n_dup    = r_dup;
        n_count  = r_count;
        case (r_state)
            lsdf_pkg::ST_IDLE: begin
                n_addr = '0;
                n_dup  = 1'b0;
            end
            lsdf_pkg::ST_SCAN: begin
                if (r_addr != r_count) begin
                    rd_en  = 1'b1;
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_rd_pend && match) begin
                    n_dup = 1'b1;
                end
            end
            lsdf_pkg::ST_DONE: begin
                res_fire = 1'b1;
                wr_en    = !r_dup && !store_full;
                if (r_last) begin
                    n_count = '0;
                end else if (wr_en) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lsdf_pkg::ST_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_dup     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_rd_pend <= rd_en;
            r_dup     <= n_dup;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_seg  <= {i_end_y, i_end_x, i_start_y, i_start_x};
            r_last <= i_last_in_frame;
        end
    end

    // ---------------- segment store ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IDX_W-1:0]] <= r_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= res_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_kept      <= !r_dup;
            r_overflow  <= !r_dup && store_full;
            r_frame_end <= r_last;
            r_out_seg   <= r_seg;
        end
    end

    assign busy             = (r_state != lsdf_pkg::ST_IDLE);
    assign o_result_valid   = r_result_valid;
    assign o_kept           = r_kept;
    assign o_store_overflow = r_overflow;
    assign o_frame_end      = r_frame_end;
    assign o_out_start_x    = r_out_seg[0*COORD_BITS +: COORD_BITS];
    assign o_out_start_y    = r_out_seg[1*COORD_BITS +: COORD_BITS];
    assign o_out_end_x      = r_out_seg[2*COORD_BITS +: COORD_BITS];
    assign o_out_end_y      = r_out_seg[3*COORD_BITS +: COORD_BITS];

    // ---------------- assertions ----------------
    `LSDF_ASSERT_NEXT(a_done_result, r_state == lsdf_pkg::ST_DONE, o_result_valid, "no strobe")
    `LSDF_ASSERT_SAME(a_count_bounded, 1'b1, r_count <= CNT_W'(MAX_SEGMENTS), "count overflow")
    `LSDF_ASSERT_SAME(a_overflow_kept, o_result_valid && o_store_overflow, o_kept, "ovf on dup")
    `LSDF_ASSERT_SAME(a_read_in_range, rd_en, r_addr < r_count, "read past fill count")

endmodule
